// ----- design/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants and types of the zone bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int ZONE_W    = 16;
    localparam int COUNT_W   = 13;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT = 1'd1;

    typedef struct packed {
        logic [ZONE_W-1:0] word;
        logic [POS_W-1:0]  pos;
    } split_t;

endpackage

// ----- design/bffa_map_ram.sv -----
// ----------------------------------------------------------------------------
// bffa_map_ram
// Allocation bitmap storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bffa_map_ram #(
    parameter int MAP_WORDS = 256,
    parameter int WORD_BITS = 32,
    parameter int AW        = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/bffa_bit_split.sv -----
// ----------------------------------------------------------------------------
// bffa_bit_split
// Split a bit index into word address and bit position, with a registered result.
// ----------------------------------------------------------------------------
module bffa_bit_split import bffa_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ZONE_W-1:0] bidx,
    output logic              done,
    output split_t            res
);

    localparam int SH     = 24;
    localparam int RECIP  = (1 << SH) / WORD_BITS;
    localparam int PROD_W = ZONE_W + SH;

    logic [PROD_W-1:0] prod;
    logic [ZONE_W-1:0] q_reg;
    logic              v1_reg;
    logic              done_reg;
    split_t            res_reg;
    logic [ZONE_W-1:0] qw;
    logic [ZONE_W-1:0] rem;
    logic [ZONE_W-1:0] wb;

    assign wb   = ZONE_W'(WORD_BITS);
    assign prod = PROD_W'(bidx) * PROD_W'(RECIP);
    assign qw   = q_reg * wb;
    assign rem  = bidx - qw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
            q_reg    <= ZONE_W'(prod >> SH);
            if (rem >= wb)
            begin
                res_reg.word <= q_reg + ZONE_W'(1);
                res_reg.pos  <= POS_W'(rem - wb);
            end
            else
            begin
                res_reg.word <= q_reg;
                res_reg.pos  <= POS_W'(rem);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- design/bffa_first_clear.sv -----
// ----------------------------------------------------------------------------
// bffa_first_clear
// Find the lowest clear bit of a map word inside the allocatable range.
// ----------------------------------------------------------------------------
module bffa_first_clear import bffa_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0] data,
    input  logic [COUNT_W-1:0]   lim,
    input  logic                 base_zero,
    output logic                 found,
    output logic [POS_W-1:0]     pos
);

    logic [WORD_BITS-1:0] cand;

    always_comb
    begin
        for (int p = 0; p < WORD_BITS; p++)
        begin
            cand[p] = !data[p] && (COUNT_W'(p) <= lim);
        end
        if (base_zero)
        begin
            cand[0] = 1'b0;
        end
        found = |cand;
        pos   = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--)
        begin
            if (cand[p])
            begin
                pos = POS_W'(p);
            end
        end
    end

endmodule

// ----- design/bitmap_first_free_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_top
// First-fit zone allocator over a bitmap held in a synchronous memory.
//
//   channel   direction  fields (low bit first)
//   s_axis    in         tdata: zone_in[15:0]; tuser: req_type
//   m_axis    out        tdata: zone_out[15:0]; tuser: status[1:0]
//   cfg       in         cfg_addr 0 first_zone, 1 zone_count; cfg_wdata[15:0]
//
// An allocate reads map words one word per cycle through the memory read
// port, at most MAP_WORDS words, and stops at the first clear bit or when the
// range holds none; with zone_count 0 it answers full without reading the map.
// A release takes an index split, one read and one write of its word; a
// release out of range reads and writes nothing. After reset a clearing pass
// writes every word while s_axis_tready stays low. One request is in
// flight at a time; a finished result waits in a holding register while the
// output register is full, and the next request is accepted once it moves on.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_top import bffa_pkg::*; #(
    parameter int MAP_WORDS = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ZONE_W-1:0]    s_axis_tdata,   // zone_in
    input  logic                 s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ZONE_W-1:0]    m_axis_tdata,   // zone_out
    output logic [1:0]           m_axis_tuser,   // status
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ZONE_W-1:0]    cfg_wdata
);

    localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BASE_W = COUNT_W + 1;
    localparam logic [AW-1:0]     LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [BASE_W-1:0] WORD_STEP = BASE_W'(WORD_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_REL_CHK,
        ST_SPLIT,
        ST_REL_RD,
        ST_REL_WR
    } state_t;

    state_t               state_reg;
    logic                 done_pend_reg;
    logic [ZONE_W-1:0]    first_zone_reg;
    logic [COUNT_W-1:0]   zone_count_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [AW-1:0]        iss_addr_reg;
    logic [BASE_W-1:0]    iss_base_reg;
    logic                 iss_on_reg;
    logic                 chk_on_reg;
    logic                 chk_last_reg;
    logic [AW-1:0]        chk_addr_reg;
    logic [BASE_W-1:0]    chk_base_reg;
    logic [COUNT_W-1:0]   chk_lim_reg;
    logic [AW-1:0]        hit_addr_reg;
    logic [BASE_W-1:0]    hit_base_reg;
    logic [POS_W-1:0]     hit_pos_reg;
    logic [WORD_BITS-1:0] hit_data_reg;
    logic [ZONE_W-1:0]    rel_bidx_reg;
    logic [ZONE_W-1:0]    rel_zone_reg;
    logic [AW-1:0]        rel_word_reg;
    logic [POS_W-1:0]     rel_pos_reg;
    logic [ZONE_W-1:0]    res_zone_reg;
    logic [1:0]           res_status_reg;
    logic                 out_valid_reg;
    logic [ZONE_W-1:0]    out_zone_reg;
    logic [1:0]           out_status_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic                 find_found;
    logic [POS_W-1:0]     find_pos;
    logic                 split_done;
    split_t               split_res;
    logic [BASE_W-1:0]    nxt_base;
    logic                 scan_last;
    logic                 out_free;
    logic                 in_fire;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign nxt_base  = iss_base_reg + WORD_STEP;
    assign scan_last = (iss_addr_reg == LAST_ADDR) || (nxt_base > BASE_W'(zone_count_reg));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = iss_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (clr_addr_reg == '0) ? WORD_BITS'(1) : '0;
            end
            ST_SCAN:
            begin
                mem_re = iss_on_reg;
            end
            ST_HIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = hit_addr_reg;
                mem_wdata = hit_data_reg | (WORD_BITS'(1) << hit_pos_reg);
            end
            ST_REL_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = rel_word_reg;
            end
            ST_REL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = rel_word_reg;
                mem_wdata = mem_rdata & ~(WORD_BITS'(1) << rel_pos_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    bffa_map_ram #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bffa_first_clear #(
        .WORD_BITS (WORD_BITS)
    ) u_first_clear (
        .data      (mem_rdata),
        .lim       (chk_lim_reg),
        .base_zero (chk_base_reg == '0),
        .found     (find_found),
        .pos       (find_pos)
    );

    bffa_bit_split #(
        .WORD_BITS (WORD_BITS)
    ) u_bit_split (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_REL_CHK),
        .bidx  (rel_bidx_reg),
        .done  (split_done),
        .res   (split_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            done_pend_reg  <= 1'b0;
            first_zone_reg <= ZONE_W'(1);
            zone_count_reg <= '1;
            clr_addr_reg   <= '0;
            iss_addr_reg   <= '0;
            iss_base_reg   <= '0;
            iss_on_reg     <= 1'b0;
            chk_on_reg     <= 1'b0;
            chk_last_reg   <= 1'b0;
            chk_addr_reg   <= '0;
            chk_base_reg   <= '0;
            chk_lim_reg    <= '0;
            hit_addr_reg   <= '0;
            hit_base_reg   <= '0;
            hit_pos_reg    <= '0;
            hit_data_reg   <= '0;
            rel_bidx_reg   <= '0;
            rel_zone_reg   <= '0;
            rel_word_reg   <= '0;
            rel_pos_reg    <= '0;
            res_zone_reg   <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_zone_reg   <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_FIRST_ZONE)
                begin
                    first_zone_reg <= cfg_wdata;
                end
                else if (cfg_addr == CFG_ZONE_COUNT)
                begin
                    zone_count_reg <= cfg_wdata[COUNT_W-1:0];
                end
            end

            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // deliver a pending result once the output register frees up
            if (done_pend_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                out_zone_reg   <= res_zone_reg;
                out_status_reg <= res_status_reg;
                done_pend_reg  <= 1'b0;
                state_reg      <= ST_IDLE;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser == REQ_RELEASE)
                        begin
                            rel_bidx_reg <= s_axis_tdata - first_zone_reg + ZONE_W'(1);
                            rel_zone_reg <= s_axis_tdata;
                            state_reg    <= ST_REL_CHK;
                        end
                        else if (zone_count_reg == '0)
                        begin
                            res_zone_reg   <= '0;
                            res_status_reg <= STATUS_FULL;
                            done_pend_reg  <= 1'b1;
                            state_reg      <= ST_SCAN;
                            iss_on_reg     <= 1'b0;
                            chk_on_reg     <= 1'b0;
                        end
                        else
                        begin
                            iss_addr_reg <= '0;
                            iss_base_reg <= '0;
                            iss_on_reg   <= 1'b1;
                            chk_on_reg   <= 1'b0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (!done_pend_reg)
                    begin
                        chk_on_reg <= iss_on_reg;
                        if (iss_on_reg)
                        begin
                            chk_addr_reg <= iss_addr_reg;
                            chk_base_reg <= iss_base_reg;
                            chk_lim_reg  <= COUNT_W'(BASE_W'(zone_count_reg) - iss_base_reg);
                            chk_last_reg <= scan_last;
                            iss_addr_reg <= iss_addr_reg + AW'(1);
                            iss_base_reg <= nxt_base;
                            iss_on_reg   <= !scan_last;
                        end
                        if (chk_on_reg)
                        begin
                            if (find_found)
                            begin
                                hit_addr_reg <= chk_addr_reg;
                                hit_base_reg <= chk_base_reg;
                                hit_pos_reg  <= find_pos;
                                hit_data_reg <= mem_rdata;
                                iss_on_reg   <= 1'b0;
                                chk_on_reg   <= 1'b0;
                                state_reg    <= ST_HIT;
                            end
                            else if (chk_last_reg)
                            begin
                                res_zone_reg   <= '0;
                                res_status_reg <= STATUS_FULL;
                                done_pend_reg  <= 1'b1;
                                iss_on_reg     <= 1'b0;
                                chk_on_reg     <= 1'b0;
                            end
                        end
                    end
                end
                ST_HIT:
                begin
                    if (!done_pend_reg)
                    begin
                        res_zone_reg   <= ZONE_W'(hit_base_reg) + ZONE_W'(hit_pos_reg)
                                          + first_zone_reg - ZONE_W'(1);
                        res_status_reg <= STATUS_OK;
                        done_pend_reg  <= 1'b1;
                    end
                end
                ST_REL_CHK:
                begin
                    if ((rel_bidx_reg == '0) || (rel_bidx_reg > ZONE_W'(zone_count_reg)))
                    begin
                        res_zone_reg   <= '0;
                        res_status_reg <= STATUS_RANGE;
                        done_pend_reg  <= 1'b1;
                        state_reg      <= ST_SPLIT;
                    end
                    else
                    begin
                        state_reg <= ST_SPLIT;
                    end
                end
                ST_SPLIT:
                begin
                    if (!done_pend_reg && split_done)
                    begin
                        if (split_res.word >= ZONE_W'(MAP_WORDS))
                        begin
                            res_zone_reg   <= '0;
                            res_status_reg <= STATUS_RANGE;
                            done_pend_reg  <= 1'b1;
                        end
                        else
                        begin
                            rel_word_reg <= AW'(split_res.word);
                            rel_pos_reg  <= split_res.pos;
                            state_reg    <= ST_REL_RD;
                        end
                    end
                end
                ST_REL_RD:
                begin
                    state_reg <= ST_REL_WR;
                end
                ST_REL_WR:
                begin
                    if (!done_pend_reg)
                    begin
                        res_zone_reg   <= rel_zone_reg;
                        res_status_reg <= STATUS_OK;
                        done_pend_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_zone_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

// ----- test/bitmap_first_free_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_top_tb
// Self-checking bench for the first-fit zone bitmap allocator. A scoreboard
// keeps its own copy of the zone bitmap and both registers, predicts the
// zone and status of every accepted request, and compares each result
// transaction in order. A short directed run covers the edges: a full map,
// out-of-range releases, release of a free zone and zone number wrap. Random
// phases use fresh register settings; both sides idle until 1000 are sent.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int MAP_WORDS   = 256;
    localparam int WORD_BITS   = 32;
    localparam int MAP_BITS    = MAP_WORDS * WORD_BITS;
    localparam int TOTAL_ITEMS = 1450;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [1:0]        status;
    } grant_t;

    class zone_grant_board;
        logic [WORD_BITS-1:0] map_words [MAP_WORDS];
        logic [ZONE_W-1:0]    first_zone;
        logic [COUNT_W-1:0]   zone_count;
        grant_t               grants_due [$];
        int                   errors;

        function new();
            foreach (map_words[i])
                map_words[i] = '0;
            map_words[0][0] = 1'b1;
            first_zone = 16'd1;
            zone_count = 13'd8191;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ZONE_W-1:0] val);
            if (idx == CFG_FIRST_ZONE)
                first_zone = val;
            else if (idx == CFG_ZONE_COUNT)
                zone_count = val[COUNT_W-1:0];
        endfunction

        function bit in_use(int b);
            return map_words[b / WORD_BITS][b % WORD_BITS];
        endfunction

        function logic [ZONE_W-1:0] zone_of(int b);
            return ZONE_W'(b + first_zone - 1);
        endfunction

        function void note_request(logic req, logic [ZONE_W-1:0] zone_in);
            grant_t            g;
            logic [ZONE_W-1:0] idx;
            int                b;
            bit                found;
            g.zone = '0;
            g.status = STATUS_OK;
            found = 1'b0;
            if (req == REQ_ALLOC)
            begin
                for (b = 1; b <= zone_count && b < MAP_BITS && !found; b++)
                begin
                    if (!in_use(b))
                    begin
                        map_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
                        g.zone = zone_of(b);
                        found = 1'b1;
                    end
                end
                if (!found)
                    g.status = STATUS_FULL;
            end
            else
            begin
                idx = zone_in - first_zone + 16'd1;
                if (idx == '0 || idx > zone_count || idx >= MAP_BITS)
                    g.status = STATUS_RANGE;
                else
                begin
                    map_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                    g.zone = zone_in;
                end
            end
            grants_due.push_back(g);
        endfunction

        function void check_grant(logic [ZONE_W-1:0] zone, logic [1:0] status);
            grant_t g;
            if (grants_due.size() == 0)
            begin
                $error("result with no request pending: zone_out %0d status %0d",
                       zone, status);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (zone !== g.zone)
            begin
                $error("zone_out: expected %0d, actual %0d", g.zone, zone);
                errors++;
            end
            if (status !== g.status)
            begin
                $error("status: expected %0d, actual %0d", g.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ZONE_W-1:0]    s_axis_tdata  = '0;    // zone_in
    logic                 s_axis_tuser  = 1'b0;  // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ZONE_W-1:0]    m_axis_tdata;          // zone_out
    logic [1:0]           m_axis_tuser;          // status
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr      = CFG_FIRST_ZONE;
    logic [ZONE_W-1:0]    cfg_wdata     = '0;

    zone_grant_board board;
    int              src_idle    = 8;
    int              snk_idle    = 62;
    int              sent        = 0;
    int              cycle_count = 0;

    bitmap_first_free_allocator_top #(
        .MAP_WORDS(MAP_WORDS),
        .WORD_BITS(WORD_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_first_free_allocator_top: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_grant(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic send_request(logic req, logic [ZONE_W-1:0] zone);
        if (sent < 500)
        begin
            src_idle = 8;
            snk_idle = 62;
        end
        else if (sent < 1000)
        begin
            src_idle = 62;
            snk_idle = 8;
        end
        else
        begin
            src_idle = 0;
            snk_idle = 0;
        end
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= zone;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(req, zone);
        sent++;
    endtask

    // hold off until every transaction in flight has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.grants_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ZONE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic configure(logic [ZONE_W-1:0] fz, logic [COUNT_W-1:0] zc);
        drain();
        write_reg(CFG_FIRST_ZONE, fz);
        write_reg(CFG_ZONE_COUNT, ZONE_W'(zc));
    endtask

    task automatic random_request(int alloc_pct);
        logic [ZONE_W-1:0] zone;
        int                b;
        int                lim;
        int                tries;
        int                r;
        zone = ZONE_W'($urandom());
        r = $urandom_range(99);
        if (r < alloc_pct)
            send_request(REQ_ALLOC, zone);
        else
        begin
            r = $urandom_range(99);
            if (r < 65 && board.zone_count != 0)
            begin
                lim = (board.zone_count > 1600) ? 1600 : board.zone_count;
                b = $urandom_range(lim, 1);
                tries = 0;
                while (!board.in_use(b) && tries < 16)
                begin
                    b = $urandom_range(lim, 1);
                    tries++;
                end
                zone = board.zone_of(b);
            end
            else if (r < 85)
                zone = board.zone_of($urandom_range(board.zone_count + 2, 0));
            send_request(REQ_RELEASE, zone);
        end
    endtask

    initial
    begin
        int                 k;
        int                 n;
        int                 pct;
        logic [ZONE_W-1:0]  fz;
        logic [COUNT_W-1:0] zc;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_RELEASE, 16'd1);
        send_request(REQ_RELEASE, 16'd1);
        send_request(REQ_RELEASE, 16'd0);
        send_request(REQ_RELEASE, 16'd8191);
        send_request(REQ_RELEASE, 16'd8192);
        send_request(REQ_RELEASE, 16'hffff);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_ALLOC, 16'hffff);

        configure(16'd1, 13'd0);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_RELEASE, 16'd1);
        send_request(REQ_RELEASE, 16'd0);

        configure(16'hffff, 13'd3);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_RELEASE, 16'hffff);
        send_request(REQ_RELEASE, 16'd0);
        send_request(REQ_RELEASE, 16'hfffe);
        send_request(REQ_RELEASE, 16'd2);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_ALLOC, 16'd0);
        send_request(REQ_RELEASE, 16'd3);

        k = 0;
        while (sent < TOTAL_ITEMS)
        begin
            unique case (k % 5)
                0:       fz = 16'd1;
                1:       fz = 16'hffff;
                3:       fz = 16'hffff - ZONE_W'($urandom_range(40, 0));
                default: fz = ZONE_W'($urandom_range(65535, 1));
            endcase
            unique case (k % 7)
                0:       zc = 13'd0;
                1:       zc = 13'd1;
                2:       zc = COUNT_W'($urandom_range(64, 2));
                3:       zc = COUNT_W'($urandom_range(300, 65));
                4:       zc = COUNT_W'($urandom_range(33, 31));
                5:       zc = 13'd8191;
                default: zc = COUNT_W'($urandom_range(8191, 301));
            endcase
            configure(fz, zc);
            n = $urandom_range(110, 40);
            if (n > TOTAL_ITEMS - sent)
                n = TOTAL_ITEMS - sent;
            pct = $urandom_range(75, 30);
            repeat (n) random_request(pct);
            k++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("bitmap_first_free_allocator_top: match");
        else
            $display("bitmap_first_free_allocator_top: mismatch");
        $finish;
    end

endmodule
